/* rtl/core/frc_pkg.sv */
// Shared types and constants for the fragment reassembly tag cache.
package frc_pkg;

  // Ring size and derived index widths
  localparam int unsigned ENTRIES     = 4;
  localparam int unsigned SLOT_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned SLOT_OUT_W  = 4;
  localparam int unsigned EXP_CNT_W   = 5;

  // Field widths
  localparam int unsigned FRAG_W      = 4;
  localparam int unsigned SEQ_W       = 12;
  localparam int unsigned QUEUE_W     = 5;
  localparam int unsigned FTYPE_W     = 2;
  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned TIMEOUT_W   = 20;

  // Configuration port
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;
  localparam logic [PADDR_W-3:0] REG_TIMEOUT_IDX = '0;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd500;

  // Transaction kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_FIND = 1'b1;

  // One cached frame tag; for a lookup key, frag holds the new fragment number
  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [QUEUE_W-1:0] queue;
    logic [FRAG_W-1:0]  frag;
    logic [FTYPE_W-1:0] ftype;
    logic [ADDR_W-1:0]  ra;
    logic [ADDR_W-1:0]  ta;
    logic [TIME_W-1:0]  tstamp;
  } frc_tag_t;

  // Result of comparing one entry against the key
  typedef struct packed {
    logic match;
    logic expired;
  } frc_cmp_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_SEARCH,
    ST_DONE
  } frc_state_e;

endpackage

/* rtl/core/fragment_reassembly_cache_top.sv */
// Top level: sequencer, configuration register and result register of the tag cache.
// A find transaction walks the slots one slot per cycle through the shared compare unit,
// newest slot first.
// Only one transaction is in flight at a time; the next is taken in the cycle after the
// result is handed over.
// Reset clears all valid bits, the write pointer and sets the timeout to 500 ticks.
module fragment_reassembly_cache_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            kind_i,
  input  logic [frc_pkg::FRAG_W-1:0]      frag_num_i,
  input  logic [frc_pkg::SEQ_W-1:0]       seq_num_i,
  input  logic [frc_pkg::QUEUE_W-1:0]     queue_id_i,
  input  logic [frc_pkg::FTYPE_W-1:0]     frame_type_i,
  input  logic [frc_pkg::ADDR_W-1:0]      receiver_addr_i,
  input  logic [frc_pkg::ADDR_W-1:0]      transmitter_addr_i,
  input  logic [frc_pkg::TIME_W-1:0]      now_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            hit_o,
  output logic [frc_pkg::SLOT_OUT_W-1:0]  slot_o,
  output logic                            evicted_o,
  output logic [frc_pkg::EXP_CNT_W-1:0]   expired_count_o,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [frc_pkg::PADDR_W-1:0]     paddr,
  input  logic [frc_pkg::PDATA_W-1:0]     pwdata,
  output logic [frc_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);
  import frc_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

  frc_state_e              state_q, state_d;
  logic [TIMEOUT_W-1:0]    timeout_q;
  logic                    kind_q, kind_d;
  frc_tag_t                key_q, key_d;
  logic [SLOT_W-1:0]       wp_q, wp_d;
  logic [SLOT_W-1:0]       idx_q, idx_d;
  logic [SLOT_W-1:0]       step_q, step_d;
  logic                    hit_q, hit_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic                    evict_q, evict_d;
  logic [EXP_CNT_W-1:0]    exp_cnt_q, exp_cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_hit_q, out_hit_d;
  logic [SLOT_OUT_W-1:0]   out_slot_q, out_slot_d;
  logic                    out_evict_q, out_evict_d;
  logic [EXP_CNT_W-1:0]    out_exp_q, out_exp_d;

  logic                    in_accept;
  logic                    out_free;
  logic                    cfg_wr;
  logic                    cfg_hit;
  logic [SLOT_W-1:0]       wp_prev;

  logic                    st_wr_en;
  logic                    st_clr_en;
  logic [SLOT_W-1:0]       st_rd_idx;
  frc_tag_t                st_wr_tag;
  frc_tag_t                st_rd_tag;
  logic                    st_rd_valid;
  frc_cmp_t                cmp_res;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign wp_prev    = (wp_q == '0) ? LAST_SLOT : wp_q - SLOT_W'(1);

  // Configuration register access
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[PADDR_W-1:2] == REG_TIMEOUT_IDX);
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;
  assign prdata  = cfg_hit ? PDATA_W'(timeout_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_wr) begin
      timeout_q <= pwdata[TIMEOUT_W-1:0];
    end
  end

  // Storage and compare unit
  assign st_wr_tag = key_q;
  assign st_rd_idx = (state_q == ST_ADD) ? wp_q : idx_q;

  frc_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (st_wr_en),
    .wr_idx_i   (wp_q),
    .wr_tag_i   (st_wr_tag),
    .clr_en_i   (st_clr_en),
    .clr_idx_i  (idx_q),
    .rd_idx_i   (st_rd_idx),
    .rd_tag_o   (st_rd_tag),
    .rd_valid_o (st_rd_valid)
  );

  frc_cmp u_cmp (
    .entry_i       (st_rd_tag),
    .entry_valid_i (st_rd_valid),
    .key_i         (key_q),
    .timeout_i     (timeout_q),
    .res_o         (cmp_res)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (kind_i == KIND_FIND) ? ST_SEARCH : ST_ADD;
        end
      end
      ST_ADD: begin
        state_d = ST_DONE;
      end
      ST_SEARCH: begin
        if ((cmp_res.match && !cmp_res.expired) || (step_q == LAST_SLOT)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer
  always_comb begin
    kind_d      = kind_q;
    key_d       = key_q;
    wp_d        = wp_q;
    idx_d       = idx_q;
    step_d      = step_q;
    hit_d       = hit_q;
    slot_d      = slot_q;
    evict_d     = evict_q;
    exp_cnt_d   = exp_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_hit_d   = out_hit_q;
    out_slot_d  = out_slot_q;
    out_evict_d = out_evict_q;
    out_exp_d   = out_exp_q;
    st_wr_en    = 1'b0;
    st_clr_en   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        // Capture the transaction and start the walk at the newest slot
        if (in_accept) begin
          kind_d       = kind_i;
          key_d.seq    = seq_num_i;
          key_d.queue  = queue_id_i;
          key_d.frag   = frag_num_i;
          key_d.ftype  = frame_type_i;
          key_d.ra     = receiver_addr_i;
          key_d.ta     = transmitter_addr_i;
          key_d.tstamp = now_i;
          idx_d        = wp_prev;
          step_d       = '0;
          hit_d        = 1'b0;
          slot_d       = '0;
          evict_d      = 1'b0;
          exp_cnt_d    = '0;
        end
      end
      ST_ADD: begin
        // Overwrite the slot at the pointer and advance with wrap
        st_wr_en = 1'b1;
        evict_d  = st_rd_valid;
        slot_d   = wp_q;
        wp_d     = (wp_q == LAST_SLOT) ? '0 : wp_q + SLOT_W'(1);
      end
      ST_SEARCH: begin
        // One slot per cycle; drop stale matches and keep going
        if (cmp_res.match && !cmp_res.expired) begin
          hit_d  = 1'b1;
          slot_d = idx_q;
        end else begin
          if (cmp_res.match) begin
            st_clr_en = 1'b1;
            exp_cnt_d = exp_cnt_q + EXP_CNT_W'(1);
          end
          idx_d  = (idx_q == '0) ? LAST_SLOT : idx_q - SLOT_W'(1);
          step_d = step_q + SLOT_W'(1);
        end
      end
      ST_DONE: begin
        // Hand the result to the output register once it is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_hit_d   = hit_q;
          out_slot_d  = SLOT_OUT_W'(slot_q);
          out_evict_d = evict_q;
          out_exp_d   = exp_cnt_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result payload registers
  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    key_q       <= key_d;
    idx_q       <= idx_d;
    step_q      <= step_d;
    hit_q       <= hit_d;
    slot_q      <= slot_d;
    evict_q     <= evict_d;
    exp_cnt_q   <= exp_cnt_d;
    out_hit_q   <= out_hit_d;
    out_slot_q  <= out_slot_d;
    out_evict_q <= out_evict_d;
    out_exp_q   <= out_exp_d;
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q && (kind_q == KIND_FIND || out_hit_q);
  assign slot_o          = out_slot_q;
  assign evicted_o       = out_evict_q;
  assign expired_count_o = out_exp_q;

endmodule

/* rtl/core/frc_store.sv */
// Tag storage ring with per-slot valid bits.
module frc_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [frc_pkg::SLOT_W-1:0]   wr_idx_i,
  input  frc_pkg::frc_tag_t            wr_tag_i,
  input  logic                         clr_en_i,
  input  logic [frc_pkg::SLOT_W-1:0]   clr_idx_i,
  input  logic [frc_pkg::SLOT_W-1:0]   rd_idx_i,
  output frc_pkg::frc_tag_t            rd_tag_o,
  output logic                         rd_valid_o
);
  import frc_pkg::*;

  logic [ENTRIES-1:0] valid_q;
  frc_tag_t           tag_q [ENTRIES];

  // Set on write, drop on expiry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (clr_en_i) begin
        valid_q[clr_idx_i] <= 1'b0;
      end
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
    end
  end

  // Tag payload, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tag_q[wr_idx_i] <= wr_tag_i;
    end
  end

  assign rd_tag_o   = tag_q[rd_idx_i];
  assign rd_valid_o = valid_q[rd_idx_i];

endmodule

/* rtl/core/frc_cmp.sv */
// Shared compare unit: tag match and wrap-safe age check for one entry.
module frc_cmp (
  input  frc_pkg::frc_tag_t                 entry_i,
  input  logic                              entry_valid_i,
  input  frc_pkg::frc_tag_t                 key_i,
  input  logic [frc_pkg::TIMEOUT_W-1:0]     timeout_i,
  output frc_pkg::frc_cmp_t                 res_o
);
  import frc_pkg::*;

  logic [FRAG_W:0]   next_frag;
  logic [TIME_W-1:0] deadline;
  logic [TIME_W-1:0] diff;

  // Expected fragment is last plus one, without wrap
  assign next_frag = {1'b0, entry_i.frag} + {{FRAG_W{1'b0}}, 1'b1};

  // Entry is stale once now is later than time plus timeout, modulo 2^32
  assign deadline = entry_i.tstamp + TIME_W'(timeout_i);
  assign diff     = deadline - key_i.tstamp;

  always_comb begin
    res_o.match = entry_valid_i
                  && (entry_i.seq == key_i.seq)
                  && (entry_i.queue == key_i.queue)
                  && (next_frag == {1'b0, key_i.frag})
                  && (entry_i.ftype == key_i.ftype)
                  && (entry_i.ra == key_i.ra)
                  && (entry_i.ta == key_i.ta);
    res_o.expired = diff[TIME_W-1];
  end

endmodule
